// ----- hw/rtl/char_to_glyph_segment_lookup_assert.svh -----
// Assertion macros for the glyph lookup block.
// Both macros sample on clk and are disabled while rst is high.
`ifndef CHAR_TO_GLYPH_SEGMENT_LOOKUP_ASSERT_SVH
`define CHAR_TO_GLYPH_SEGMENT_LOOKUP_ASSERT_SVH

`ifndef SYNTH
`define C2G_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glyph lookup assertion failed");
`define C2G_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glyph lookup assertion failed");
`else
`define C2G_ASSERT_SAME(lbl, ante, cons)
`define C2G_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/c2g_pkg.sv -----
package c2g_pkg;

  // table memory geometry
  localparam int TABLE_WORDS = 4096;
  localparam int TBL_AW      = $clog2(TABLE_WORDS);
  // wide enough for range-offset address + offset/2 + (code - start)
  localparam int CALC_W      = 18;

  // subtable layout offsets, in words from the subtable base
  localparam logic [CALC_W-1:0] END_OFS = CALC_W'(7);
  localparam logic [CALC_W-1:0] SEG_OFS = CALC_W'(8);

  localparam logic [15:0] END_MARK = 16'hFFFF;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // register index (paddr[2])
  localparam logic REG_SEG_COUNT = 1'b0;
  localparam logic REG_SUB_BASE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END_RQ,
    ST_END_CHK,
    ST_START_RQ,
    ST_START_CHK,
    ST_RO_RQ,
    ST_RO_CHK,
    ST_GW_RQ,
    ST_GW_CHK,
    ST_DELTA_RQ,
    ST_DELTA_CHK,
    ST_DONE
  } st_t;

endpackage

// ----- hw/rtl/char_to_glyph_segment_lookup.sv -----
// Character code to glyph index lookup over a segment-format character map.
// Request channel (req_valid / req_stall): one beat is either a table write
// (command = write: word_value stored at word_address) or a lookup
// (command = lookup: char_code). A beat is taken when valid is high and stall
// is low. Writes produce no response; lookups produce exactly one.
// Response channel (rsp_valid / rsp_stall): glyph_index, found, address_error.
// The APB port sets segment_count (byte address 0) and subtable_base (4);
// write it only while the block is idle.
// A write is stored when its beat is taken. A lookup walks segments in
// order through the table memory: an end code read and compare for each
// segment passed over, then start, range offset, glyph word and delta
// reads as the segment needs, and a hand-off of the result from the done
// state. One lookup is in flight at a time; stall is held for its duration,
// so no write can overlap a table read.
// Reset clears the control state and the config registers; table contents
// are undefined until written. A stalled response holds its beat; a finished
// lookup waits in the done state until the response register frees up.
`include "char_to_glyph_segment_lookup_assert.svh"

module char_to_glyph_segment_lookup
  import c2g_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        command,
  input  logic [11:0] word_address,
  input  logic [15:0] word_value,
  input  logic [15:0] char_code,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] glyph_index,
  output logic        found,
  output logic        address_error,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- config
  logic [9:0]  segment_count;
  logic [11:0] subtable_base;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= '0;
      subtable_base <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SEG_COUNT: segment_count <= pwdata[9:0];
        REG_SUB_BASE:  subtable_base <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SEG_COUNT: prdata = 32'(segment_count);
      REG_SUB_BASE:  prdata = 32'(subtable_base);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- table memory
  logic [15:0]       table_mem [TABLE_WORDS];
  logic              mem_we;
  logic              mem_re;
  logic [CALC_W-1:0] wr_calc;
  logic [CALC_W-1:0] rd_calc;
  logic [15:0]       rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_calc[TBL_AW-1:0]] <= word_value;
    end
    if (mem_re) begin
      rdata <= table_mem[rd_calc[TBL_AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- sequencer
  st_t               state, state_next;
  logic [15:0]       code, code_next;
  logic [9:0]        seg_idx, seg_idx_next;
  logic [15:0]       start_code, start_code_next;
  logic [15:0]       range_off, range_off_next;
  logic [CALC_W-1:0] ro_addr, ro_addr_next;
  logic [15:0]       base_val, base_val_next;   // code or glyph word, delta added later
  logic [15:0]       res_glyph, res_glyph_next;
  logic              res_found, res_found_next;
  logic              res_err, res_err_next;

  logic        req_acc;
  logic        out_load;
  logic        fin;
  logic [15:0] fin_glyph;
  logic        fin_found;
  logic        fin_err;
  logic        oob;

  logic [CALC_W-1:0] base_w, n_w, i_w;
  logic [CALC_W-1:0] end_addr, start_addr, delta_addr, ro_addr_calc, glyph_addr;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign wr_calc   = CALC_W'(word_address);
  assign mem_we    = req_acc && (command == CMD_WRITE) &&
                     (wr_calc < CALC_W'(TABLE_WORDS));

  // subtable word addresses for the current segment
  assign base_w       = CALC_W'(subtable_base);
  assign n_w          = CALC_W'(segment_count);
  assign i_w          = CALC_W'(seg_idx);
  assign end_addr     = base_w + END_OFS + i_w;
  assign start_addr   = base_w + SEG_OFS + n_w + i_w;
  assign delta_addr   = base_w + SEG_OFS + (n_w << 1) + i_w;
  assign ro_addr_calc = base_w + SEG_OFS + (n_w << 1) + n_w + i_w;
  assign glyph_addr   = ro_addr + CALC_W'(range_off[15:1]) + CALC_W'(code - start_code);

  // read address picked by state alone, so the range check feeds the
  // sequencer without looping back through it
  always_comb begin
    case (state)
      ST_START_RQ: rd_calc = start_addr;
      ST_RO_RQ:    rd_calc = ro_addr_calc;
      ST_GW_RQ:    rd_calc = glyph_addr;
      ST_DELTA_RQ: rd_calc = delta_addr;
      default:     rd_calc = end_addr;
    endcase
  end

  assign oob = (rd_calc >= CALC_W'(TABLE_WORDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    code       <= code_next;
    seg_idx    <= seg_idx_next;
    start_code <= start_code_next;
    range_off  <= range_off_next;
    ro_addr    <= ro_addr_next;
    base_val   <= base_val_next;
    res_glyph  <= res_glyph_next;
    res_found  <= res_found_next;
    res_err    <= res_err_next;
  end

  always_comb begin
    state_next      = state;
    code_next       = code;
    seg_idx_next    = seg_idx;
    start_code_next = start_code;
    range_off_next  = range_off;
    ro_addr_next    = ro_addr;
    base_val_next   = base_val;
    res_glyph_next  = res_glyph;
    res_found_next  = res_found;
    res_err_next    = res_err;
    mem_re          = 1'b0;
    out_load        = 1'b0;
    fin             = 1'b0;
    fin_glyph       = '0;
    fin_found       = 1'b0;
    fin_err         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_acc && (command == CMD_LOOKUP)) begin
          code_next    = char_code;
          seg_idx_next = '0;
          if (segment_count == '0) begin
            fin = 1'b1;
          end else begin
            state_next = ST_END_RQ;
          end
        end
      end
      ST_END_RQ: begin
        if (oob) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_END_CHK;
        end
      end
      ST_END_CHK: begin
        if (rdata == END_MARK) begin
          fin = 1'b1;
        end else if (code > rdata) begin
          // segment lies below the code: move on, or run out of segments
          if (seg_idx == segment_count - 10'd1) begin
            fin = 1'b1;
          end else begin
            seg_idx_next = seg_idx + 10'd1;
            state_next   = ST_END_RQ;
          end
        end else begin
          state_next = ST_START_RQ;
        end
      end
      ST_START_RQ: begin
        if (oob) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_START_CHK;
        end
      end
      ST_START_CHK: begin
        start_code_next = rdata;
        if (code < rdata) begin
          fin = 1'b1;
        end else begin
          state_next = ST_RO_RQ;
        end
      end
      ST_RO_RQ: begin
        ro_addr_next = ro_addr_calc;
        if (oob) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_RO_CHK;
        end
      end
      ST_RO_CHK: begin
        range_off_next = rdata;
        if (rdata == '0) begin
          base_val_next = code;
          state_next    = ST_DELTA_RQ;
        end else begin
          state_next = ST_GW_RQ;
        end
      end
      ST_GW_RQ: begin
        if (oob) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_GW_CHK;
        end
      end
      ST_GW_CHK: begin
        if (rdata == '0) begin
          fin       = 1'b1;
          fin_found = 1'b1;
        end else begin
          base_val_next = rdata;
          state_next    = ST_DELTA_RQ;
        end
      end
      ST_DELTA_RQ: begin
        if (oob) begin
          fin     = 1'b1;
          fin_err = 1'b1;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_DELTA_CHK;
        end
      end
      ST_DELTA_CHK: begin
        fin       = 1'b1;
        fin_found = 1'b1;
        fin_glyph = base_val + rdata;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fin) begin
      res_glyph_next = fin_glyph;
      res_found_next = fin_found;
      res_err_next   = fin_err;
      state_next     = ST_DONE;
    end
  end

  // ---------------------------------------------------------------- response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      glyph_index   <= res_glyph;
      found         <= res_found;
      address_error <= res_err;
    end
  end

  // ---------------------------------------------------------------- checks
  `C2G_ASSERT_SAME(a_no_rw_clash, mem_we, !mem_re)
  `C2G_ASSERT_SAME(a_err_not_found, rsp_valid, !(found && address_error))
  `C2G_ASSERT_NEXT(a_lookup_starts, req_acc && (command == CMD_LOOKUP), state != ST_IDLE)
  `C2G_ASSERT_NEXT(a_done_waits, (state == ST_DONE) && rsp_valid && rsp_stall,
                   state == ST_DONE)

endmodule

// ----- dv/char_to_glyph_segment_lookup_tb.sv -----
`timescale 1ns / 1ps

module char_to_glyph_segment_lookup_tb;
  import c2g_pkg::*;

  // scan outcome codes for the table walk
  localparam int FAULT_NONE = 0;
  localparam int FAULT_OOB  = 1;
  localparam int FAULT_HOLE = 2;

  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [15:0] glyph;
    logic        hit;
    logic        oob;
  } glyph_result_t;

  // one request beat plus the lookup result it must produce
  typedef struct packed {
    logic          command;
    logic [11:0]   word_address;
    logic [15:0]   word_value;
    logic [15:0]   char_code;
    glyph_result_t want;
  } req_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        command = CMD_WRITE;
  logic [11:0] word_address = '0;
  logic [15:0] word_value = '0;
  logic [15:0] char_code = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] glyph_index;
  logic        found;
  logic        address_error;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  char_to_glyph_segment_lookup uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .command(command),
    .word_address(word_address), .word_value(word_value), .char_code(char_code),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .glyph_index(glyph_index),
    .found(found), .address_error(address_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: table memory, which words have been written, and the
  // two layout registers. Lookups are predicted when they are queued; since
  // beats are taken in order and registers only change while idle, the
  // prediction matches what the block sees when it takes the beat.
  // ---------------------------------------------------------------------------
  logic [15:0]  tbl_mem     [TABLE_WORDS];
  bit           tbl_written [TABLE_WORDS];
  int unsigned  n_seg = 0;
  int unsigned  sub_base = 0;
  int           scan_fault;
  int           hole_addr;

  req_beat_t    pending_beats[$];   // beats not yet driven
  req_beat_t    glyph_expect[$];    // lookups taken, response outstanding
  req_beat_t    cur_beat;
  int unsigned  seg_lo[$];          // code ranges of the current layout
  int unsigned  seg_hi[$];
  int           item_count = 0;

  int           bad_beats = 0;
  int           n_writes = 0, n_lookups = 0;
  int           n_hits = 0, n_miss = 0, n_oob = 0;
  int           layouts = 0;

  logic         req_fire = 1'b0;
  int           req_gap = 0;
  int           rsp_hold = 0;
  bit           calm = 1'b0;

  task automatic note_fail(input string msg);
    bad_beats++;
    if (bad_beats <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Table read as the block does it; flags out-of-range and unwritten words.
  function automatic logic [15:0] peek(input int unsigned a);
    if (a >= TABLE_WORDS) begin
      scan_fault = FAULT_OOB;
      return 16'h0000;
    end
    if (!tbl_written[a]) begin
      scan_fault = FAULT_HOLE;
      hole_addr  = a;
      return 16'h0000;
    end
    return tbl_mem[a];
  endfunction

  // Walks the segments for one code. Returns the address of the first
  // unwritten word it would touch, or -1 with the result filled in.
  function automatic int scan_table(input logic [15:0] code, output glyph_result_t res);
    int unsigned ro_at;
    logic [15:0] endc, startc, ro, delta, word;
    res = '0;
    scan_fault = FAULT_NONE;
    for (int unsigned i = 0; i < n_seg; i++) begin
      endc = peek(sub_base + 7 + i);
      if (scan_fault != FAULT_NONE || endc == END_MARK) break;
      if (code > endc) continue;
      // first segment ending at or above the code: hit or stop here
      startc = peek(sub_base + 8 + n_seg + i);
      if (scan_fault != FAULT_NONE || code < startc) break;
      ro_at = sub_base + 8 + 3 * n_seg + i;
      ro = peek(ro_at);
      if (scan_fault != FAULT_NONE) break;
      // zero range offset maps the code itself; otherwise fetch the glyph
      // word, offset halved so an odd offset drops its low bit
      if (ro == 16'h0000) word = code;
      else word = peek(ro_at + (ro >> 1) + (code - startc));
      if (scan_fault != FAULT_NONE) break;
      if (ro != 16'h0000 && word == 16'h0000) begin
        res.glyph = 16'h0000;   // contained, but the glyph word is empty
      end else begin
        delta = peek(sub_base + 8 + 2 * n_seg + i);
        if (scan_fault != FAULT_NONE) break;
        res.glyph = word + delta;
      end
      res.hit = 1'b1;
      break;
    end
    if (scan_fault == FAULT_HOLE) return hole_addr;
    if (scan_fault == FAULT_OOB) begin
      res = '0;
      res.oob = 1'b1;
    end
    return -1;
  endfunction

  function automatic void push_write(input int unsigned a, input logic [15:0] v);
    req_beat_t b;
    if (a >= TABLE_WORDS) return;
    tbl_mem[a]     = v;
    tbl_written[a] = 1'b1;
    b.command      = CMD_WRITE;
    b.word_address = 12'(a);
    b.word_value   = v;
    b.char_code    = 16'($urandom);
    b.want         = '0;
    pending_beats.push_back(b);
    item_count++;
  endfunction

  // Any word the walk would read before it is written gets written first,
  // so the block never reads undefined memory.
  function automatic void push_lookup(input logic [15:0] code);
    req_beat_t     b;
    glyph_result_t res;
    int            hole;
    hole = scan_table(code, res);
    while (hole >= 0) begin
      push_write(hole, 16'($urandom));
      hole = scan_table(code, res);
    end
    b.command      = CMD_LOOKUP;
    b.word_address = 12'($urandom);
    b.word_value   = 16'($urandom);
    b.char_code    = code;
    b.want         = res;
    pending_beats.push_back(b);
    item_count++;
  endfunction

  function automatic void put_seg(input int unsigned i, input logic [15:0] s,
                                  input logic [15:0] e, input logic [15:0] d,
                                  input logic [15:0] r);
    push_write(sub_base + 7 + i, e);
    push_write(sub_base + 8 + n_seg + i, s);
    push_write(sub_base + 8 + 2 * n_seg + i, d);
    push_write(sub_base + 8 + 3 * n_seg + i, r);
  endfunction

  // Well-formed layout of k segments spread over the code space, each with
  // a zero range offset, a glyph array slice, or an offset far past memory.
  function automatic void build_layout(input int unsigned k, input bit term);
    int unsigned slot, lo, s, e, span, g_at, ro_at, mode;
    logic [15:0] d, r;
    seg_lo.delete();
    seg_hi.delete();
    slot = 65535 / k;
    g_at = sub_base + 8 + 4 * n_seg;
    for (int unsigned i = 0; i < k; i++) begin
      if (term && i == k - 1) begin
        put_seg(i, END_MARK, END_MARK, 16'h0001, 16'h0000);
        seg_lo.push_back(65535);
        seg_hi.push_back(65535);
      end else begin
        mode = $urandom_range(9, 0);
        span = slot / 2 - 1;
        if (mode >= 5 && mode < 9 && span > 15) span = 15;
        lo = i * slot;
        s  = lo + $urandom_range(slot / 2, 0);
        e  = s + $urandom_range(span, 0);
        d  = ($urandom_range(7, 0) == 0) ? 16'hFFFF : 16'($urandom);
        ro_at = sub_base + 8 + 3 * n_seg + i;
        if (mode < 5) begin
          r = 16'h0000;
        end else if (mode < 9) begin
          r = 16'(2 * (g_at - ro_at) + $urandom_range(1, 0));
          for (int unsigned c = 0; c <= e - s; c++)
            push_write(g_at + c, ($urandom_range(3, 0) == 0) ? 16'h0000 : 16'($urandom));
          g_at += e - s + 1;
        end else begin
          r = 16'hFFF0 | 16'($urandom_range(15, 0));
        end
        put_seg(i, 16'(s), 16'(e), d, r);
        seg_lo.push_back(s);
        seg_hi.push_back(e);
      end
    end
  endfunction

  // Codes mostly fall within or just outside a segment's range; some are fully random or extreme.
  function automatic logic [15:0] pick_code();
    int unsigned r, j, lo, hi;
    r = $urandom_range(9, 0);
    if (seg_lo.size() == 0 || r < 2) return 16'($urandom);
    if (r == 2) return ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
    j  = $urandom_range(seg_lo.size() - 1, 0);
    lo = (seg_lo[j] < 2) ? 0 : seg_lo[j] - 2;
    hi = (seg_hi[j] > 65533) ? 65535 : seg_hi[j] + 2;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Lookups with some stray writes mixed in, partly into the live layout.
  function automatic void lookup_burst(input int cnt);
    int unsigned top;
    for (int c = 0; c < cnt; c++) begin
      if ($urandom_range(9, 0) == 0) begin
        top = sub_base + 8 + 4 * n_seg;
        if (top >= TABLE_WORDS) top = TABLE_WORDS - 1;
        if ($urandom_range(1, 0) != 0) push_write($urandom_range(TABLE_WORDS - 1, 0),
                                                  16'($urandom));
        else push_write($urandom_range(top, sub_base), 16'($urandom));
      end else begin
        push_lookup(pick_code());
      end
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // One APB transfer: setup at a falling edge, access on the next, done at
  // the rising edge where pready is seen.
  task automatic apb_xfer(input logic wr, input logic idx, input logic [31:0] wval,
                          output logic [31:0] rval);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wval;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rval = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_layout(input int unsigned cnt, input int unsigned base);
    logic        idx [2];
    logic [31:0] val [2];
    logic [31:0] rd;
    idx[0] = REG_SEG_COUNT;
    idx[1] = REG_SUB_BASE;
    val[0] = cnt;
    val[1] = base;
    for (int r = 0; r < 2; r++) apb_xfer(1'b1, idx[r], val[r], rd);
    for (int r = 0; r < 2; r++) begin
      apb_xfer(1'b0, idx[r], 32'h0, rd);
      if (rd !== val[r])
        note_fail($sformatf("register %0d read back %h, wrote %h", r, rd, val[r]));
    end
    n_seg    = cnt;
    sub_base = base;
    layouts++;
  endtask

  // Block is idle once every beat is taken and every lookup answered; a
  // drain wait follows before returning.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || req_valid || glyph_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: pops the next beat at a falling edge once the previous one
  // was taken, with random gaps between beats. Payload holds while stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && !req_fire) begin
        // beat still waiting on stall: hold everything
      end else if (req_gap > 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_beats.size() != 0) begin
        cur_beat     <= pending_beats[0];
        command      <= pending_beats[0].command;
        word_address <= pending_beats[0].word_address;
        word_value   <= pending_beats[0].word_value;
        char_code    <= pending_beats[0].char_code;
        req_valid    <= 1'b1;
        req_gap      <= pick_gap();
        void'(pending_beats.pop_front());
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stall: random holds, and now and then a quiet stretch where
  // neither side idles.
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(299, 0) == 0) calm <= !calm;
      if (rsp_hold > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold  <= rsp_hold - 1;
      end else if (!calm && $urandom_range(3, 0) == 0) begin
        rsp_stall <= 1'b1;
        rsp_hold  <= pick_gap();
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: records taken lookups, checks each response beat against the
  // oldest outstanding one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_beat_t b;
    req_fire <= req_valid && !req_stall;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        if (cur_beat.command == CMD_LOOKUP) begin
          glyph_expect.push_back(cur_beat);
          n_lookups++;
        end else begin
          n_writes++;
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (glyph_expect.size() == 0) begin
          note_fail($sformatf("response beat with no lookup pending: glyph %h found %b err %b",
                              glyph_index, found, address_error));
        end else begin
          b = glyph_expect.pop_front();
          if (glyph_index !== b.want.glyph || found !== b.want.hit ||
              address_error !== b.want.oob)
            note_fail($sformatf("char %h: want glyph %h found %b err %b, got %h %b %b",
                                b.char_code, b.want.glyph, b.want.hit, b.want.oob,
                                glyph_index, found, address_error));
          if (b.want.oob) n_oob++;
          else if (b.want.hit) n_hits++;
          else n_miss++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int unsigned k, base;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero segment count after reset: nothing matches, nothing is read.
    push_lookup(16'h0000);
    push_lookup(16'hFFFF);
    push_write(0, 16'h0000);
    push_write(TABLE_WORDS - 1, 16'hFFFF);
    wait_idle();

    // Hand-built three segment map: a single-code segment whose delta wraps,
    // a glyph-array segment with an odd range offset (holds a zero glyph and
    // a wrapping word), and the end marker segment.
    set_layout(3, 100);
    put_seg(0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    put_seg(1, 16'h0020, 16'h0023, 16'h0002, 16'h0005);
    put_seg(2, END_MARK, END_MARK, 16'h0001, 16'h0000);
    push_write(sub_base + 8 + 4 * n_seg + 0, 16'h0007);
    push_write(sub_base + 8 + 4 * n_seg + 1, 16'h0000);
    push_write(sub_base + 8 + 4 * n_seg + 2, 16'hFFFF);
    push_write(sub_base + 8 + 4 * n_seg + 3, 16'h0003);
    push_lookup(16'h0000);
    push_lookup(16'h0010);     // falls in the gap before segment 1
    for (int c = 16'h20; c <= 16'h24; c++) push_lookup(16'(c));
    push_lookup(16'hFFFF);     // end marker stops the scan
    wait_idle();

    // Subtable at the top word: the first end code lies past memory.
    set_layout(3, TABLE_WORDS - 1);
    push_lookup(16'h0041);
    wait_idle();

    // Random layouts until enough beats have gone out.
    item_count = 0;
    phase = 0;
    while (item_count < RANDOM_ITEMS) begin
      case (phase % 6)
        1: begin
          set_layout(0, $urandom_range(TABLE_WORDS - 1, 0));
          seg_lo.delete();
          seg_hi.delete();
          lookup_burst(12);
        end
        3: begin
          // largest segment count, base at zero; the end marker keeps scans short
          set_layout(1023, 0);
          build_layout($urandom_range(20, 6), 1'b1);
          lookup_burst($urandom_range(30, 15));
        end
        5: begin
          // largest count high in memory: start or offset reads run off the end
          set_layout(1023, $urandom_range(4000, 3000));
          build_layout($urandom_range(12, 4), 1'b1);
          lookup_burst($urandom_range(30, 15));
        end
        default: begin
          k = $urandom_range(40, 1);
          if ($urandom_range(7, 0) == 0) base = $urandom_range(TABLE_WORDS - 1, 0);
          else base = $urandom_range(TABLE_WORDS - 1 - (8 + 4 * k) - 64, 0);
          set_layout(k, base);
          build_layout(k, $urandom_range(1, 0));
          lookup_burst($urandom_range(80, 40));
        end
      endcase
      wait_idle();
      phase++;
    end

    if (glyph_expect.size() != 0)
      note_fail($sformatf("%0d lookups never answered", glyph_expect.size()));
    $display("covered %0d table writes and %0d lookups across %0d register settings",
             n_writes, n_lookups, layouts);
    $display("lookup outcomes: %0d mapped, %0d unmapped, %0d address faults",
             n_hits, n_miss, n_oob);
    if (bad_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching beats", bad_beats);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #30_000_000;
    $display("timeout waiting for handshakes");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
